// ===== sv/prfs_pkg.sv =====
package prfs_pkg;

	localparam int DEF_ROWS      = 1024;
	localparam int DEF_ROW_WORDS = 8;
	localparam int COLS          = 16;
	localparam int GROUP_BITS    = 28;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 5;

	localparam logic [CFG_IW-1:0] CFG_VECTORS  = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_BOOLEANS = 1'd1;

	typedef enum logic [2:0] {
		REQ_LAYOUT    = 3'd0,
		REQ_SET_CELL  = 3'd1,
		REQ_GET_CELL  = 3'd2,
		REQ_SET_GROUP = 3'd3,
		REQ_GET_GROUP = 3'd4,
		REQ_REGROUP   = 3'd5
	} req_code_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [9:0]         row;
		logic [3:0]         col;
		logic signed [63:0] value;
		logic [2:0]         layout_word;
		logic [3:0]         layout_offset;
		logic [3:0]         layout_bytes;
		logic [27:0]        match_grp;
		logic [27:0]        grp_if_clear;
		logic [27:0]        grp_if_set;
		logic               regroup_bit;
	} req_t;

	typedef struct packed {
		logic signed [63:0] read_value;
		logic [27:0]        group_out;
		logic               status;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  word;
		logic [3:0]  offset;
		logic [3:0]  bytes;
		logic [63:0] base;
	} layout_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} stat_t;

endpackage

// ===== sv/prfs_ctrl.sv =====
module prfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  prfs_pkg::stat_t stat,
	output prfs_pkg::cmd_t  cmd
);
	import prfs_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   proceed;

	assign proceed   = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE:  cmd.accept = req_valid;
			ST_EXEC:  cmd.exec = proceed;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: if (stat.clear_last) state_q <= ST_IDLE;
				ST_IDLE:  if (req_valid) state_q <= ST_EXEC;
				ST_EXEC:  if (proceed) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			// load a new beat, or drop the one just taken
			if (cmd.exec)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without an executed item");

	a_exec_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> ($past(state_q == ST_IDLE) || $past(state_q == ST_EXEC)))
		else $error("execute entered without an accepted item");

endmodule

// ===== sv/prfs_dpath.sv =====
module prfs_dpath #(
	parameter int ROWS      = prfs_pkg::DEF_ROWS,
	parameter int ROW_WORDS = prfs_pkg::DEF_ROW_WORDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  prfs_pkg::cmd_t              cmd,
	output prfs_pkg::stat_t             stat,
	input  logic                        cfg_we,
	input  logic [prfs_pkg::CFG_IW-1:0] cfg_index,
	input  logic [prfs_pkg::CFG_DW-1:0] cfg_data,
	input  prfs_pkg::req_t              req,
	output prfs_pkg::rsp_t              rsp
);
	import prfs_pkg::*;

	localparam int TOTAL = ROWS * ROW_WORDS;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int ADW   = (AW > 16) ? AW : 16;
	localparam logic [16:0] ROWS_L  = 17'(ROWS);
	localparam logic [20:0] TOTAL_L = 21'(TOTAL);
	localparam logic [4:0]  COLS_L  = 5'(COLS);
	localparam logic [63:0] GRP_FIELD_MASK = 64'((65'd1 << GROUP_BITS) - 65'd1);

	// configuration, kept in the form the address path needs
	logic [3:0] eff_vec_q;
	logic [4:0] stride_q;
	logic [4:0] booleans_q;
	logic [3:0] v_new;
	logic [3:0] ev_new;
	logic [4:0] ev_inc;

	assign v_new  = cfg_data[3:0];
	assign ev_new = (v_new == 4'd0) ? 4'd1 : v_new;
	assign ev_inc = {1'b0, ev_new} + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_vec_q  <= 4'd1;
			stride_q   <= 5'd1;
			booleans_q <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VECTORS: begin
					eff_vec_q <= ev_new;
					stride_q  <= (ev_new == 4'd1) ? 5'd1 : {ev_inc[4:1], 1'b0};
				end
				CFG_BOOLEANS: booleans_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// column layout table
	layout_t lay_q [COLS];
	layout_t lay_rd;

	assign lay_rd = lay_q[req.col];

	// item capture and address check
	req_t            item_q;
	layout_t         lay_s1;
	logic            bool_s1;
	logic            bad_s1;
	logic [AW-1:0]   addr_s1;

	logic            is_cell;
	logic            is_bool;
	logic            col_oor;
	logic [2:0]      word_sel;
	logic [15:0]     addr_full;
	logic [ADW-1:0]  addr_ext;
	logic            row_ok;
	logic            addr_ok;
	logic            word_ok;
	logic            bad;

	always_comb begin
		is_cell   = req.req_type inside {REQ_SET_CELL, REQ_GET_CELL};
		is_bool   = {1'b0, req.col} < booleans_q;
		col_oor   = {1'b0, req.col} >= COLS_L;
		word_sel  = (is_cell && !is_bool) ? lay_rd.word : 3'd0;
		addr_full = 16'(req.row * stride_q) + {13'd0, word_sel};
		addr_ext  = ADW'(addr_full);
		row_ok    = {7'd0, req.row} < ROWS_L;
		addr_ok   = {5'd0, addr_full} < TOTAL_L;
		word_ok   = {1'b0, lay_rd.word} < eff_vec_q;
		case (req.req_type)
			REQ_LAYOUT:   bad = col_oor;
			REQ_SET_CELL,
			REQ_GET_CELL: bad = col_oor || !row_ok || !addr_ok || (!is_bool && !word_ok);
			REQ_SET_GROUP,
			REQ_GET_GROUP,
			REQ_REGROUP:  bad = !row_ok || !addr_ok;
			default:      bad = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_s1 <= 1'b1;
		end else if (cmd.accept) begin
			bad_s1 <= bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q  <= req;
			lay_s1  <= lay_rd;
			bool_s1 <= is_bool;
			addr_s1 <= addr_ext[AW-1:0];
		end
	end

	// word memory with clearing sweep
	logic [127:0]  mem [TOTAL];
	logic [127:0]  rdata_q;
	logic [AW-1:0] clr_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [127:0]  mem_wdata;
	logic          exec_wr;
	logic [127:0]  new_word;

	assign stat.clear_last = (clr_q == AW'(TOTAL - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear && !stat.clear_last)
			clr_q <= clr_q + AW'(1);
	end

	assign mem_we    = cmd.clear || exec_wr;
	assign mem_waddr = cmd.clear ? clr_q : addr_s1;
	assign mem_wdata = cmd.clear ? 128'd0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (cmd.accept)
			rdata_q <= mem[addr_ext[AW-1:0]];
	end

	// field update and extraction
	logic [63:0] diff;
	logic [63:0] lo;
	logic [5:0]  bpos;
	logic [3:0]  len;
	logic [3:0]  rel;
	logic [4:0]  pos;
	logic [63:0] rd_bytes;
	logic [63:0] rdv;
	logic [GROUP_BITS-1:0] grp_cur;
	logic [27:0] grp_new;
	logic        grp_hit;
	rsp_t        rsp_next;

	always_comb begin
		diff     = item_q.value - lay_s1.base;
		lo       = rdata_q[63:0];
		bpos     = 6'(GROUP_BITS) + {2'd0, item_q.col};
		len      = (lay_s1.bytes > 4'd8) ? 4'd8 : lay_s1.bytes;
		new_word = rdata_q;
		rd_bytes = '0;
		rel      = '0;
		pos      = '0;
		grp_cur  = lo[GROUP_BITS-1:0];
		grp_hit  = ({4'd0, item_q.match_grp} == 32'(grp_cur));
		grp_new  = item_q.regroup_bit ? item_q.grp_if_set : item_q.grp_if_clear;

		for (int k = 0; k < 16; k++) begin
			rel = 4'(k) - lay_s1.offset;
			if ((4'(k) >= lay_s1.offset) && (rel < len))
				new_word[k*8 +: 8] = diff[rel[2:0]*8 +: 8];
		end
		for (int j = 0; j < 8; j++) begin
			pos = {1'b0, lay_s1.offset} + 5'(j);
			if ((4'(j) < len) && !pos[4])
				rd_bytes[j*8 +: 8] = rdata_q[pos[3:0]*8 +: 8];
		end

		// boolean and group writes touch only the low half; keep the rest of the word
		if (bool_s1) begin
			rdv = {63'd0, lo[bpos]} + lay_s1.base;
			new_word = {rdata_q[127:64], lo | (64'(diff[0]) << bpos)};
		end else begin
			rdv = rd_bytes + lay_s1.base;
		end

		rsp_next = '0;
		exec_wr  = 1'b0;
		if (bad_s1) begin
			rsp_next.status = 1'b1;
		end else begin
			case (item_q.req_type)
				REQ_SET_CELL: exec_wr = cmd.exec;
				REQ_GET_CELL: rsp_next.read_value = rdv;
				REQ_SET_GROUP: begin
					new_word = {rdata_q[127:64],
						(lo & ~GRP_FIELD_MASK) | (item_q.value & GRP_FIELD_MASK)};
					exec_wr = cmd.exec;
				end
				REQ_GET_GROUP: rsp_next.group_out = 28'(grp_cur);
				REQ_REGROUP: begin
					if (grp_hit) begin
						new_word = {rdata_q[127:64],
							(lo & ~GRP_FIELD_MASK) | (64'(grp_new) & GRP_FIELD_MASK)};
						rsp_next.group_out = 28'(64'(grp_new) & GRP_FIELD_MASK);
						exec_wr = cmd.exec;
					end else begin
						rsp_next.group_out = 28'(grp_cur);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !bad_s1 && (item_q.req_type == REQ_LAYOUT)) begin
			lay_q[item_q.col].word   <= item_q.layout_word;
			lay_q[item_q.col].offset <= item_q.layout_offset;
			lay_q[item_q.col].bytes  <= item_q.layout_bytes;
			lay_q[item_q.col].base   <= item_q.value;
		end
		if (cmd.exec)
			rsp <= rsp_next;
	end

	a_no_write_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && bad_s1) |-> !mem_we)
		else $error("store written by an ignored item");

	a_clear_holds_items: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (!cmd.accept && !cmd.exec))
		else $error("item handled during clearing sweep");

endmodule

// ===== sv/packed_row_field_store_unit.sv =====
// channel   | signals                       | beat taken when
// ----------+-------------------------------+--------------------------
// request   | req_valid, req_stall, req     | req_valid && !req_stall
// response  | rsp_valid, rsp_stall, rsp     | rsp_valid && !rsp_stall
// config    | cfg_we, cfg_index, cfg_data   | cfg_we
//
// Each item has two steps: its 128-bit word is read when the item is taken,
// then, for writes, changed and stored through the memory's single write port.
// After reset the memory is swept to zero, one word a cycle, over all words
// (ROWS*ROW_WORDS, 8192 by default); no request is taken during the sweep.
// A stalled response holds the next item in its execute cycle; one more item
// may be taken while a response waits.
module packed_row_field_store_unit #(
	parameter int ROWS      = prfs_pkg::DEF_ROWS,
	parameter int ROW_WORDS = prfs_pkg::DEF_ROW_WORDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  prfs_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output prfs_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [prfs_pkg::CFG_IW-1:0] cfg_index,
	input  logic [prfs_pkg::CFG_DW-1:0] cfg_data
);
	import prfs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	prfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	prfs_dpath #(
		.ROWS      (ROWS),
		.ROW_WORDS (ROW_WORDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

endmodule
